>>> rtl/core/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types, character codes and status codes for the RPN evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

	localparam int DATA_W = 32;
	localparam int CHAR_W = 8;

	// ASCII codes of the accepted tokens
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'd42;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'd47;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_BADCHAR       = 3'd1,
		ST_UNSEP         = 3'd2,
		ST_BADAFTERSPACE = 3'd3,
		ST_UNDERFLOW     = 3'd4,
		ST_DIVZERO       = 3'd5,
		ST_COUNT         = 3'd6,
		ST_OVERFLOW      = 3'd7
	} status_t;

	// class of the previous character
	typedef enum logic [1:0] {
		CLS_START = 2'd0,
		CLS_TOKEN = 2'd1,
		CLS_SPACE = 2'd2,
		CLS_OTHER = 2'd3
	} cls_t;

	// control from the sequencer to the format checker
	typedef struct packed {
		logic              step;
		logic              clear;
		logic [CHAR_W-1:0] character;
	} fmt_ctl_t;

	function automatic logic is_digit(logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_op(logic [CHAR_W-1:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
	endfunction

endpackage

>>> rtl/core/rpn_ram.sv
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rpn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/rpn_div.sv
// ----------------------------------------------------------------------------
// rpn_div
// Restoring signed divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module rpn_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rpn_pkg::DATA_W-1:0] dividend,
	input  logic [rpn_pkg::DATA_W-1:0] divisor,
	output logic                      done,
	output logic [rpn_pkg::DATA_W-1:0] quotient
);

	localparam int W  = rpn_pkg::DATA_W;
	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  mb_q;
	logic          neg_q;

	logic [W-1:0]  mag_a;
	logic [W-1:0]  mag_b;
	logic [W:0]    shifted;
	logic [W:0]    diff;

	// magnitudes of the operands
	assign mag_a = dividend[W-1] ? (W'(0) - dividend) : dividend;
	assign mag_b = divisor[W-1]  ? (W'(0) - divisor)  : divisor;

	// trial subtraction of one step
	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, mb_q};

	// iterate over the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			mb_q   <= '0;
			neg_q  <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CW'(W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= mag_a;
				mb_q   <= mag_b;
				neg_q  <= dividend[W-1] ^ divisor[W-1];
			end else if (busy_q) begin
				if (!diff[W]) begin
					rem_q <= diff[W-1:0];
				end else begin
					rem_q <= shifted[W-1:0];
				end
				quo_q <= {quo_q[W-2:0], ~diff[W]};
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// apply the sign of the quotient
	assign done     = done_q;
	assign quotient = neg_q ? (W'(0) - quo_q) : quo_q;

endmodule

>>> rtl/core/rpn_fmt.sv
// ----------------------------------------------------------------------------
// rpn_fmt
// Token and separator check on each pair of adjacent characters.
// ----------------------------------------------------------------------------
module rpn_fmt (
	input  logic              clk,
	input  logic              arst_n,
	input  rpn_pkg::fmt_ctl_t ctl,
	output logic [1:0]        err
);

	rpn_pkg::cls_t prev_q;
	logic [1:0]    err_q;
	rpn_pkg::cls_t cls;
	logic          tok;

	// classify the incoming character
	always_comb begin
		tok = rpn_pkg::is_digit(ctl.character) || rpn_pkg::is_op(ctl.character);
		if (tok) begin
			cls = rpn_pkg::CLS_TOKEN;
		end else if (ctl.character == rpn_pkg::CH_SPACE) begin
			cls = rpn_pkg::CLS_SPACE;
		end else begin
			cls = rpn_pkg::CLS_OTHER;
		end
	end

	// keep the first format error and the class of the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= rpn_pkg::CLS_START;
			err_q  <= '0;
		end else if (ctl.clear) begin
			prev_q <= rpn_pkg::CLS_START;
			err_q  <= '0;
		end else if (ctl.step) begin
			if (err_q == 2'(rpn_pkg::ST_OK)) begin
				if (prev_q == rpn_pkg::CLS_TOKEN && ctl.character != rpn_pkg::CH_SPACE) begin
					err_q <= 2'(rpn_pkg::ST_UNSEP);
				end else if (prev_q == rpn_pkg::CLS_SPACE && !tok) begin
					err_q <= 2'(rpn_pkg::ST_BADAFTERSPACE);
				end else if (cls == rpn_pkg::CLS_OTHER) begin
					err_q <= 2'(rpn_pkg::ST_BADCHAR);
				end
			end
			prev_q <= cls;
		end
	end

	assign err = err_q;

endmodule

>>> rtl/core/rpn_expression_evaluator.sv
// ----------------------------------------------------------------------------
// rpn_expression_evaluator
// Reverse Polish evaluator over a stream of ASCII characters; the stack sits
// in a RAM with the top entry held in a register.
// ----------------------------------------------------------------------------
// Digits, spaces and other characters are handled in the idle state; + - *
// pass through the read state (one RAM read of the second entry); / also
// waits in the divide state for the bit-serial divider. The end item
// loads the result register, or first waits until a pending result is taken.
// Reset clears the stack count, error flags and handshakes; the stack RAM
// is not cleared, as only written entries are ever read.
module rpn_expression_evaluator #(
	parameter int STACK_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: [7:0] character
	input  logic [7:0]  s_tdata,
	// s_tlast: end_marker
	input  logic        s_tlast,
	input  logic        s_tvalid,
	output logic        s_tready,
	// m_tdata: [31:0] value
	output logic [31:0] m_tdata,
	// m_tuser: [2:0] status
	output logic [2:0]  m_tuser,
	output logic        m_tvalid,
	input  logic        m_tready
);

	localparam int W  = rpn_pkg::DATA_W;
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_DIV,
		S_FLUSH
	} state_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	state_t           state_q;
	op_t              op_q;
	logic [CW-1:0]    count_q;
	logic [W-1:0]     top_q;
	rpn_pkg::status_t eval_err_q;
	logic             out_valid_q;
	logic [W-1:0]     out_value_q;
	rpn_pkg::status_t out_status_q;

	logic             accept;
	logic             out_free;
	logic             load_out;
	logic [CW-1:0]    cnt_m1;
	logic [CW-1:0]    cnt_m2;
	logic             ram_we;
	logic [W-1:0]     ram_rdata;
	logic [W-1:0]     alu_res;
	logic             div_start;
	logic             div_done;
	logic [W-1:0]     div_quo;
	logic [1:0]       fmt_err;
	rpn_pkg::fmt_ctl_t fmt_ctl;
	rpn_pkg::status_t fin_status;
	logic [7:0]       digit;
	op_t              op_code;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign load_out = ((state_q == S_IDLE) && accept && s_tlast && out_free)
	               || ((state_q == S_FLUSH) && out_free);
	assign cnt_m1   = count_q - CW'(1);
	assign cnt_m2   = count_q - CW'(2);
	assign digit    = s_tdata - rpn_pkg::CH_ZERO;

	// push writes the old top below the new one
	assign ram_we = accept && !s_tlast && (eval_err_q == rpn_pkg::ST_OK)
	             && rpn_pkg::is_digit(s_tdata) && (count_q < CW'(STACK_DEPTH))
	             && (count_q != '0);

	rpn_ram #(
		.WIDTH(W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_m1[AW-1:0]),
		.wdata(top_q),
		.raddr(cnt_m2[AW-1:0]),
		.rdata(ram_rdata)
	);

	// format checker steps on every character and clears with the result
	assign fmt_ctl.step      = accept && !s_tlast;
	assign fmt_ctl.clear     = load_out;
	assign fmt_ctl.character = s_tdata;

	rpn_fmt u_fmt (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (fmt_ctl),
		.err   (fmt_err)
	);

	assign div_start = (state_q == S_READ) && (op_q == OP_DIV);

	rpn_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(ram_rdata),
		.divisor (top_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	// decode the operator character
	always_comb begin
		unique case (s_tdata)
			rpn_pkg::CH_PLUS:  op_code = OP_ADD;
			rpn_pkg::CH_MINUS: op_code = OP_SUB;
			rpn_pkg::CH_STAR:  op_code = OP_MUL;
			default:           op_code = OP_DIV;
		endcase
	end

	// combine the second entry with the top
	always_comb begin
		case (op_q)
			OP_ADD:  alu_res = ram_rdata + top_q;
			OP_SUB:  alu_res = ram_rdata - top_q;
			default: alu_res = ram_rdata * top_q;
		endcase
	end

	// final status, format errors first
	always_comb begin
		if (fmt_err != 2'd0) begin
			fin_status = rpn_pkg::status_t'({1'b0, fmt_err});
		end else if (eval_err_q != rpn_pkg::ST_OK) begin
			fin_status = eval_err_q;
		end else if (count_q != CW'(1)) begin
			fin_status = rpn_pkg::ST_COUNT;
		end else begin
			fin_status = rpn_pkg::ST_OK;
		end
	end

	// sequencer, stack top and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_ADD;
			count_q      <= '0;
			top_q        <= '0;
			eval_err_q   <= rpn_pkg::ST_OK;
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_status_q <= rpn_pkg::ST_OK;
		end else begin
			if (load_out) begin
				out_valid_q  <= 1'b1;
				out_status_q <= fin_status;
				out_value_q  <= (fin_status == rpn_pkg::ST_OK) ? top_q : '0;
				count_q      <= '0;
				eval_err_q   <= rpn_pkg::ST_OK;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && s_tlast && !out_free) begin
						state_q <= S_FLUSH;
					end else if (accept && !s_tlast && eval_err_q == rpn_pkg::ST_OK) begin
						if (rpn_pkg::is_digit(s_tdata)) begin
							if (count_q >= CW'(STACK_DEPTH)) begin
								eval_err_q <= rpn_pkg::ST_OVERFLOW;
							end else begin
								top_q   <= {{(W-8){1'b0}}, digit};
								count_q <= count_q + CW'(1);
							end
						end else if (rpn_pkg::is_op(s_tdata)) begin
							if (count_q < CW'(2)) begin
								eval_err_q <= rpn_pkg::ST_UNDERFLOW;
							end else if (s_tdata == rpn_pkg::CH_SLASH && top_q == '0) begin
								eval_err_q <= rpn_pkg::ST_DIVZERO;
							end else begin
								op_q    <= op_code;
								state_q <= S_READ;
							end
						end
					end
				end
				S_READ: begin
					if (op_q == OP_DIV) begin
						state_q <= S_DIV;
					end else begin
						top_q   <= alu_res;
						count_q <= cnt_m1;
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						top_q   <= div_quo;
						count_q <= cnt_m1;
						state_q <= S_IDLE;
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = out_status_q;

endmodule

>>> rtl/core/rpn_checker.sv
// ----------------------------------------------------------------------------
// rpn_checker
// Port-level checks on the evaluator's result channel, bound to the top.
// ----------------------------------------------------------------------------
module rpn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tlast,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tvalid,
	input logic        m_tready
);

	// hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// a failed expression reports a zero value
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != 3'd0) |-> (m_tdata == 32'd0))
		else $error("non-zero value with error status");

	// an end request with a free output gives a result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast && !m_tvalid |=> m_tvalid)
		else $error("end request gave no result");

	// a new result follows an end request or a stalled input side
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast) || $past(!s_tready))
		else $error("result without end request");

endmodule

bind rpn_expression_evaluator rpn_checker u_rpn_checker (.*);
